// ----- rtl/rwnt_pkg.sv -----
// Shared types and constants for the receive window NACK tracker.
`timescale 1ns / 1ps
`default_nettype none
package rwnt_pkg;

  localparam int SEQ_BITS_DEF     = 10;
  localparam int CHANNEL_BITS_DEF = 4;
  localparam int WORD_W           = 16;
  localparam int STATUS_W         = 4;
  localparam int LIMIT_W          = 6;
  localparam int CFG_DATA_W       = 8;
  localparam int CFG_INDEX_W      = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_CHANNEL = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_LIMIT  = 1'b1;
  localparam logic [LIMIT_W-1:0]     LIMIT_RESET       = 6'd63;

  typedef enum logic [1:0] {
    MODE_ARRIVE  = 2'd0,
    MODE_CONSUME = 2'd1,
    MODE_REPORT  = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    RS_NEW        = 4'd0,
    RS_DUPLICATE  = 4'd1,
    RS_STALE      = 4'd2,
    RS_MISMATCH   = 4'd3,
    RS_TOO_FAR    = 4'd4,
    RS_DELIVERED  = 4'd5,
    RS_NONE_READY = 4'd6,
    RS_REPORT     = 4'd7,
    RS_OVERFLOW   = 4'd8
  } rslt_t;

  typedef enum logic [2:0] {
    ADR_SEQ,
    ADR_NEXT,
    ADR_DU,
    ADR_PTR,
    ADR_PTR_INC
  } addr_sel_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_INC,
    PTR_NEWEST_INC,
    PTR_DU
  } ptr_op_t;

  typedef enum logic [1:0] {
    WSEL_RUN,
    WSEL_SAT,
    WSEL_FINAL
  } wsel_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_A_CHK,
    ST_FWD,
    ST_C_CHK,
    ST_R_OUTER,
    ST_R_OCHK,
    ST_R_INNER,
    ST_R_ICHK
  } state_t;

  typedef struct packed {
    logic      latch;
    logic      mem_rd;
    logic      mem_wr;
    logic      wr_bit;
    addr_sel_t asel;
    ptr_op_t   pop;
    logic      set_rr;
    logic      newest_to_seq;
    logic      du_adv;
    logic      start_ld;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      n_clr;
    logic      emit;
    rslt_t     est;
    wsel_t     wsel;
    logic      elast;
    logic      report;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  chan_ok;
    logic  in_win;
    logic  fwd;
    logic  too_far;
    logic  rd_bit;
    logic  ptr_all_ones;
    logic  ptr_at_seq;
    logic  ptr_at_newest;
    logic  ptr_inc_newest;
    logic  cnt_full;
    logic  over;
    logic  out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/receive_window_nack_tracker_top.sv -----
// Each request is taken in IDLE and decoded in DECODE. A mismatch, stale or too-far arrive
// is answered from DECODE; an in-window arrive checks its slot in A_CHK, a consume in C_CHK;
// a forward jump clears each skipped slot in FWD. A NACK report walks the window slot by slot
// and ends with the final word; a full output register stalls each emit. One request is
// processed at a time. A finished result waits in the output register while the next request is taken.
// After reset the bitmap is swept clear first, one slot per cycle, over all 2^SEQ_BITS slots.
`timescale 1ns / 1ps
`default_nettype none
module receive_window_nack_tracker_top
  import rwnt_pkg::*;
#(
  parameter int SEQ_BITS     = SEQ_BITS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  localparam int IN_TDATA_W  = ((SEQ_BITS + CHANNEL_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((WORD_W + SEQ_BITS + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // seq, channel
  input  wire logic [1:0]             in_tuser,   // mode
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // word, delivered_seq
  output logic [STATUS_W-1:0]         out_tuser,  // status
  output logic                        out_tlast,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t                cmd;
  dp_sts_t             sts;
  logic [WORD_W-1:0]   word;
  logic [SEQ_BITS-1:0] deliv;

  assign cfg_ready = 1'b1;

  rwnt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rwnt_dpath #(
    .SEQ_BITS     (SEQ_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_tuser),
    .in_seq     (in_tdata[SEQ_BITS-1:0]),
    .in_chan    (in_tdata[SEQ_BITS+CHANNEL_BITS-1:SEQ_BITS]),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_word   (word),
    .out_deliv  (deliv),
    .out_last   (out_tlast)
  );

  assign out_tdata = OUT_TDATA_W'({deliv, word});

endmodule
`default_nettype wire

// ----- rtl/rwnt_ctrl.sv -----
// Controller state machine for the receive window NACK tracker.
`timescale 1ns / 1ps
`default_nettype none
module rwnt_ctrl
  import rwnt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  input  wire dp_sts_t sts,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.ptr_all_ones) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts.mode)
          MODE_ARRIVE: begin
            if (!sts.chan_ok) begin
              if (sts.out_free) state_nxt = ST_IDLE;
            end else if (sts.in_win) begin
              state_nxt = ST_A_CHK;
            end else if (sts.fwd) begin
              state_nxt = ST_FWD;
            end else if (sts.out_free) begin
              state_nxt = ST_IDLE;
            end
          end
          MODE_CONSUME: state_nxt = ST_C_CHK;
          MODE_REPORT:  state_nxt = ST_R_OUTER;
          default:      state_nxt = ST_IDLE;
        endcase
      end
      ST_A_CHK, ST_C_CHK: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_FWD: begin
        if (sts.ptr_at_seq && sts.out_free) state_nxt = ST_IDLE;
      end
      ST_R_OUTER: begin
        if (sts.ptr_at_newest) begin
          if (sts.out_free) state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_R_OCHK;
        end
      end
      ST_R_OCHK: begin
        state_nxt = sts.rd_bit ? ST_R_OUTER : ST_R_INNER;
      end
      ST_R_INNER: begin
        if (sts.ptr_inc_newest) begin
          if (sts.out_free) state_nxt = sts.over ? ST_IDLE : ST_R_OUTER;
        end else begin
          state_nxt = ST_R_ICHK;
        end
      end
      ST_R_ICHK: begin
        if (sts.rd_bit) begin
          if (sts.out_free) state_nxt = sts.over ? ST_IDLE : ST_R_OUTER;
        end else if (sts.cnt_full) begin
          if (sts.out_free) state_nxt = sts.over ? ST_IDLE : ST_R_INNER;
        end else begin
          state_nxt = ST_R_INNER;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.asel = ADR_PTR;
    cmd.pop  = PTR_HOLD;
    cmd.est  = RS_NEW;
    cmd.wsel = WSEL_RUN;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.mem_wr = 1'b1;
        cmd.pop    = PTR_INC;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      ST_DECODE: begin
        case (sts.mode)
          MODE_ARRIVE: begin
            if (!sts.chan_ok) begin
              cmd.set_rr = sts.out_free;
              cmd.emit   = sts.out_free;
              cmd.est    = RS_MISMATCH;
            end else if (sts.in_win) begin
              cmd.mem_rd = 1'b1;
              cmd.asel   = ADR_SEQ;
            end else if (sts.fwd) begin
              cmd.pop = PTR_NEWEST_INC;
            end else begin
              cmd.emit = sts.out_free;
              cmd.est  = sts.too_far ? RS_TOO_FAR : RS_STALE;
            end
          end
          MODE_CONSUME: begin
            cmd.mem_rd = 1'b1;
            cmd.asel   = ADR_NEXT;
          end
          MODE_REPORT: begin
            cmd.pop   = PTR_DU;
            cmd.n_clr = 1'b1;
          end
          default: ;
        endcase
      end
      ST_A_CHK: begin
        cmd.emit   = sts.out_free;
        cmd.est    = sts.rd_bit ? RS_DUPLICATE : RS_NEW;
        cmd.mem_wr = sts.out_free && !sts.rd_bit;
        cmd.wr_bit = 1'b1;
        cmd.asel   = ADR_SEQ;
      end
      ST_FWD: begin
        if (sts.ptr_at_seq) begin
          // land the new newest slot
          cmd.mem_wr        = sts.out_free;
          cmd.wr_bit        = 1'b1;
          cmd.asel          = ADR_SEQ;
          cmd.newest_to_seq = sts.out_free;
          cmd.emit          = sts.out_free;
          cmd.est           = RS_NEW;
        end else begin
          cmd.mem_wr = 1'b1;
          cmd.pop    = PTR_INC;
        end
      end
      ST_C_CHK: begin
        cmd.emit   = sts.out_free;
        cmd.est    = sts.rd_bit ? RS_DELIVERED : RS_NONE_READY;
        cmd.mem_wr = sts.out_free && sts.rd_bit;
        cmd.asel   = ADR_DU;
        cmd.du_adv = sts.out_free && sts.rd_bit;
      end
      ST_R_OUTER: begin
        if (sts.ptr_at_newest) begin
          cmd.emit   = sts.out_free;
          cmd.report = 1'b1;
          cmd.est    = RS_REPORT;
          cmd.wsel   = WSEL_FINAL;
          cmd.elast  = 1'b1;
        end else begin
          cmd.pop    = PTR_INC;
          cmd.mem_rd = 1'b1;
          cmd.asel   = ADR_PTR_INC;
        end
      end
      ST_R_OCHK: begin
        cmd.start_ld = !sts.rd_bit;
        cmd.cnt_clr  = !sts.rd_bit;
      end
      ST_R_INNER: begin
        if (sts.ptr_inc_newest) begin
          cmd.pop    = sts.out_free ? PTR_INC : PTR_HOLD;
          cmd.emit   = sts.out_free;
          cmd.report = 1'b1;
          cmd.est    = RS_REPORT;
        end else begin
          cmd.pop    = PTR_INC;
          cmd.mem_rd = 1'b1;
          cmd.asel   = ADR_PTR_INC;
        end
      end
      ST_R_ICHK: begin
        if (sts.rd_bit) begin
          cmd.emit   = sts.out_free;
          cmd.report = 1'b1;
          cmd.est    = RS_REPORT;
        end else if (sts.cnt_full) begin
          // split a saturated run and restart at this slot
          cmd.emit     = sts.out_free;
          cmd.report   = 1'b1;
          cmd.est      = RS_REPORT;
          cmd.wsel     = WSEL_SAT;
          cmd.start_ld = sts.out_free;
          cmd.cnt_clr  = sts.out_free;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/rwnt_dpath.sv -----
// Datapath for the receive window NACK tracker: window state, bitmap and result register.
`timescale 1ns / 1ps
`default_nettype none
module rwnt_dpath
  import rwnt_pkg::*;
#(
  parameter int SEQ_BITS     = SEQ_BITS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cmd_t                    cmd,
  output dp_sts_t                      sts,
  input  wire logic [1:0]              in_mode,
  input  wire logic [SEQ_BITS-1:0]     in_seq,
  input  wire logic [CHANNEL_BITS-1:0] in_chan,
  input  wire logic                    cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                    out_tready,
  output logic                         out_valid,
  output logic [STATUS_W-1:0]          out_status,
  output logic [WORD_W-1:0]            out_word,
  output logic [SEQ_BITS-1:0]          out_deliv,
  output logic                         out_last
);

  localparam int SPACE      = 1 << SEQ_BITS;
  localparam int COUNT_BITS = WORD_W - SEQ_BITS;
  localparam logic [SEQ_BITS-1:0] HALF    = SEQ_BITS'(1) << (SEQ_BITS - 1);
  localparam logic [SEQ_BITS-1:0] QUARTER = SEQ_BITS'(1) << (SEQ_BITS - 2);

  logic                    mem [SPACE];
  logic                    rd_bit_r;
  logic [SEQ_BITS-1:0]     du_r, newest_r, ptr_r, ptr_nxt, start_r, seq_r, addr;
  logic [CHANNEL_BITS-1:0] chan_r, local_chan_r;
  logic [1:0]              mode_r;
  logic [COUNT_BITS-1:0]   cnt_r;
  logic [LIMIT_W-1:0]      n_r, limit_r;
  logic                    rr_r;
  logic                    out_valid_r, out_last_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [WORD_W-1:0]       out_word_r, word_sel;
  logic [SEQ_BITS-1:0]     out_deliv_r;
  logic [SEQ_BITS-1:0]     du_inc, ptr_inc, d_off, w_off, ahead, behind;
  logic                    over;

  assign du_inc  = du_r + SEQ_BITS'(1);
  assign ptr_inc = ptr_r + SEQ_BITS'(1);
  assign d_off   = seq_r - du_r;
  assign w_off   = newest_r - du_r;
  assign ahead   = seq_r - newest_r;
  assign behind  = du_r - seq_r;
  assign over    = (n_r >= limit_r);

  always_comb begin
    case (cmd.asel)
      ADR_SEQ:     addr = seq_r;
      ADR_NEXT:    addr = du_inc;
      ADR_DU:      addr = du_r;
      ADR_PTR_INC: addr = ptr_inc;
      default:     addr = ptr_r;
    endcase
  end

  always_comb begin
    case (cmd.pop)
      PTR_INC:        ptr_nxt = ptr_inc;
      PTR_NEWEST_INC: ptr_nxt = newest_r + SEQ_BITS'(1);
      PTR_DU:         ptr_nxt = du_r;
      default:        ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    case (cmd.wsel)
      WSEL_SAT:   word_sel = {start_r, {COUNT_BITS{1'b1}}};
      WSEL_FINAL: word_sel = {ptr_inc, {COUNT_BITS{1'b0}}};
      default:    word_sel = {start_r, cnt_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[addr] <= cmd.wr_bit;
    if (cmd.mem_rd) rd_bit_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      du_r         <= '1;
      newest_r     <= '1;
      ptr_r        <= '0;
      rr_r         <= 1'b0;
      local_chan_r <= '0;
      limit_r      <= LIMIT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
      if (cmd.du_adv)        du_r     <= du_inc;
      if (cmd.newest_to_seq) newest_r <= seq_r;
      if (cmd.set_rr)        rr_r     <= 1'b1;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LOCAL_CHANNEL: local_chan_r <= cfg_data[CHANNEL_BITS-1:0];
          CFG_REPORT_LIMIT:  limit_r      <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.emit)      out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_mode;
      seq_r  <= in_seq;
      chan_r <= in_chan;
    end
    if (cmd.start_ld) start_r <= ptr_r;
    if (cmd.cnt_clr)      cnt_r <= '0;
    else if (cmd.cnt_inc) cnt_r <= cnt_r + COUNT_BITS'(1);
    if (cmd.n_clr) n_r <= '0;
    else if (cmd.emit && cmd.report && !over) n_r <= n_r + LIMIT_W'(1);
    if (cmd.emit) begin
      if (cmd.report && over) begin
        out_status_r <= RS_OVERFLOW;
        out_word_r   <= '0;
        out_last_r   <= 1'b1;
      end else begin
        out_status_r <= cmd.est;
        out_word_r   <= cmd.report ? word_sel : '0;
        out_last_r   <= cmd.report ? cmd.elast : 1'b1;
      end
      out_deliv_r <= (cmd.est == RS_DELIVERED) ? du_inc : '0;
    end
  end

  always_comb begin
    sts.mode           = mode_t'(mode_r);
    sts.chan_ok        = (chan_r == local_chan_r);
    sts.in_win         = (d_off <= w_off);
    sts.fwd            = (ahead < HALF);
    sts.too_far        = (behind > QUARTER);
    sts.rd_bit         = rd_bit_r;
    sts.ptr_all_ones   = &ptr_r;
    sts.ptr_at_seq     = (ptr_r == seq_r);
    sts.ptr_at_newest  = (ptr_r == newest_r);
    sts.ptr_inc_newest = (ptr_inc == newest_r);
    sts.cnt_full       = &cnt_r;
    sts.over           = over;
    sts.out_free       = !out_valid_r || out_tready;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_word   = out_word_r;
  assign out_deliv  = out_deliv_r;
  assign out_last   = out_last_r;

  a_rr_sticky: assert property (@(posedge clk) disable iff (!rst_n) rr_r |=> rr_r)
    else $error("reset request dropped");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_tready))
    else $error("result written over a pending one");
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mem_rd && cmd.mem_wr))
    else $error("bitmap read and write in one cycle");
  a_du_only_on_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.du_adv |-> (cmd.emit && cmd.est == RS_DELIVERED))
    else $error("window advanced without delivery");

endmodule
`default_nettype wire

// ----- test/receive_window_nack_tracker_top_test.sv -----
// Self-checking testbench for the receive window NACK tracker top level.
`timescale 1ns / 1ps
`default_nettype none
module receive_window_nack_tracker_top_test;
  import rwnt_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES  = 64;

  typedef struct {
    rslt_t       status;
    logic [15:0] word;
    logic [9:0]  dseq;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = MODE_NONE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = CFG_LOCAL_CHANNEL;
  logic [7:0]  cfg_data = '0;

  receive_window_nack_tracker_top u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #6 clk = ~clk;

  // window model
  bit          window_map [1024];
  logic [9:0]  delivered_upto;
  logic [9:0]  newest_seq;
  logic [3:0]  local_channel;
  logic [5:0]  word_limit;
  result_t     pending_results [$];
  int          report_count;
  bit          report_stop;

  int errors = 0;
  int idle_cycles = 0;
  bit burst_mode = 0;
  bit rx_steady = 0;
  int rx_hold_req = 0;
  int rx_hold_cnt = 0;

  task automatic push_result(rslt_t st, logic [15:0] w, logic [9:0] d, logic l);
    result_t r;
    r.status = st; r.word = w; r.dseq = d; r.last = l;
    pending_results.push_back(r);
  endtask

  task automatic push_word(logic [15:0] w, logic fin);
    if (report_count + 1 > word_limit) begin
      report_stop = 1;
      push_result(RS_OVERFLOW, '0, '0, 1'b1);
    end else begin
      push_result(RS_REPORT, w, '0, fin);
    end
    report_count++;
  endtask

  task automatic predict_request(mode_t mode, logic [9:0] seq, logic [3:0] chan);
    logic [9:0] d, w, p, start, i;
    int cnt;
    case (mode)
      MODE_ARRIVE: begin
        d = seq - delivered_upto;
        w = newest_seq - delivered_upto;
        if (chan != local_channel) begin
          push_result(RS_MISMATCH, '0, '0, 1'b1);
        end else if (d <= w) begin
          push_result(window_map[seq] ? RS_DUPLICATE : RS_NEW, '0, '0, 1'b1);
          window_map[seq] = 1;
        end else if (10'(seq - newest_seq) < 10'd512) begin
          for (i = seq; i != newest_seq; i = i - 1'b1) window_map[i] = 0;
          window_map[seq] = 1;
          newest_seq = seq;
          push_result(RS_NEW, '0, '0, 1'b1);
        end else if (10'(delivered_upto - seq) > 10'd256) begin
          push_result(RS_TOO_FAR, '0, '0, 1'b1);
        end else begin
          push_result(RS_STALE, '0, '0, 1'b1);
        end
      end
      MODE_CONSUME: begin
        p = delivered_upto + 1'b1;
        if (!window_map[p]) begin
          push_result(RS_NONE_READY, '0, '0, 1'b1);
        end else begin
          window_map[delivered_upto] = 0;
          delivered_upto = p;
          push_result(RS_DELIVERED, '0, p, 1'b1);
        end
      end
      MODE_REPORT: begin
        report_count = 0;
        report_stop = 0;
        p = delivered_upto;
        while (p != newest_seq && !report_stop) begin
          p = p + 1'b1;
          if (!window_map[p]) begin
            start = p;
            cnt = 0;
            while (1) begin
              p = p + 1'b1;
              if (p == newest_seq || window_map[p]) break;
              cnt++;
              if (cnt == 64) begin
                // saturated run: emit and restart at this slot
                push_word({start, 6'h3f}, 1'b0);
                if (report_stop) break;
                start = p;
                cnt = 0;
              end
            end
            if (!report_stop) push_word({start, 6'(cnt)}, 1'b0);
          end
        end
        if (!report_stop) push_word({10'(p + 1'b1), 6'd0}, 1'b1);
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 40) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(mode_t mode, logic [9:0] seq, logic [3:0] chan);
    int gap;
    bit ok;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, chan, seq};
    in_tuser  <= mode;
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    predict_request(mode, seq, chan);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [0:0] idx, logic [7:0] val);
    bit ok;
    stop_sending();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    if (idx == CFG_LOCAL_CHANNEL) local_channel = val[3:0];
    else word_limit = val[5:0];
  endtask

  // Arrivals near the window head, fill-ins and noise, plus consumes, reports and unused modes.
  task automatic send_random_request();
    int r;
    logic [9:0] w;
    r = $urandom_range(0, 99);
    w = newest_seq - delivered_upto;
    if (r < 40)
      send_request(MODE_ARRIVE, newest_seq + 10'($urandom_range(1, 4)), local_channel);
    else if (r < 55)
      send_request(MODE_ARRIVE, delivered_upto + 10'($urandom_range(0, w + 1)),
                   local_channel);
    else if (r < 60)
      send_request(MODE_ARRIVE, 10'($urandom), local_channel);
    else if (r < 63)
      send_request(MODE_ARRIVE, 10'($urandom), 4'($urandom));
    else if (r < 92)
      send_request(MODE_CONSUME, 10'($urandom), 4'($urandom));
    else if (r < 98)
      send_request(MODE_REPORT, 10'($urandom), 4'($urandom));
    else
      send_request(MODE_NONE, 10'($urandom), 4'($urandom));
  endtask

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d word=%h dseq=%0d last=%0b", $time,
                 out_tuser, out_tdata[15:0], out_tdata[25:16], out_tlast);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_tuser !== e.status || out_tdata[15:0] !== e.word ||
            out_tdata[25:16] !== e.dseq || out_tlast !== e.last) begin
          $display("%0t: mismatch expected status=%0d word=%h dseq=%0d last=%0b",
                   $time, e.status, e.word, e.dseq, e.last);
          $display("%0t:          actual   status=%0d word=%h dseq=%0d last=%0b",
                   $time, out_tuser, out_tdata[15:0], out_tdata[25:16], out_tlast);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_cnt = rx_hold_req;
      rx_hold_req = 0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_cnt > 0) begin
      rx_hold_cnt--;
      out_tready <= 1'b0;
    end else if (rx_steady) begin
      out_tready <= 1'b1;
    end else begin
      if ($urandom_range(0, 59) == 0) rx_hold_cnt = $urandom_range(10, 50);
      out_tready <= ($urandom_range(0, 99) < 70);
    end
  end

  // watchdog on forward progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** receive_window_nack_tracker_top: FAILED **");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(MODE_ARRIVE, 10'd0, 4'd0);      // forward by one
    send_request(MODE_ARRIVE, 10'd0, 4'd0);      // duplicate
    send_request(MODE_ARRIVE, 10'd1023, 4'd0);   // inside window, absent
    send_request(MODE_ARRIVE, 10'd3, 4'd15);     // channel mismatch
    send_request(MODE_ARRIVE, 10'd5, 4'd0);      // jump clears skipped slots
    send_request(MODE_REPORT, 10'd0, 4'd0);
    send_request(MODE_CONSUME, 10'd0, 4'd0);
    send_request(MODE_CONSUME, 10'd0, 4'd0);     // nothing ready
    send_request(MODE_ARRIVE, 10'd0, 4'd0);      // repeat of delivered slot
    send_request(MODE_ARRIVE, 10'd700, 4'd0);    // far behind
    send_request(MODE_ARRIVE, 10'd1000, 4'd0);   // stale
    send_request(MODE_NONE, 10'h3ff, 4'hf);      // unused mode
    send_request(MODE_ARRIVE, 10'd300, 4'd0);    // long jump: saturated runs
    send_request(MODE_ARRIVE, 10'd100, 4'd0);
    send_request(MODE_REPORT, 10'd0, 4'd0);
    send_request(MODE_ARRIVE, 10'd1, 4'd0);
    send_request(MODE_CONSUME, 10'd0, 4'd0);
    send_request(MODE_CONSUME, 10'd0, 4'd0);
    send_request(MODE_ARRIVE, 10'd2, 4'd0);
    send_request(MODE_CONSUME, 10'd0, 4'd0);
  endtask

  task automatic test_config();
    write_register(CFG_REPORT_LIMIT, 8'd1);
    send_request(MODE_REPORT, 10'd0, 4'd0);      // overflows on the second word
    write_register(CFG_REPORT_LIMIT, 8'd2);
    send_request(MODE_REPORT, 10'd0, 4'd0);
    write_register(CFG_LOCAL_CHANNEL, 8'd15);
    send_request(MODE_ARRIVE, 10'd4, 4'd0);
    send_request(MODE_ARRIVE, 10'd4, 4'd15);
    write_register(CFG_REPORT_LIMIT, 8'd63);
    send_request(MODE_REPORT, 10'd0, 4'd0);
  endtask

  task automatic test_random(int count);
    for (int k = 0; k < count; k++) begin
      if (k % 60 == 0) begin
        burst_mode = ($urandom_range(0, 3) == 0);
        rx_steady  = ($urandom_range(0, 3) == 0);
      end
      if (k % 120 == 119) begin
        write_register(CFG_LOCAL_CHANNEL, 8'($urandom_range(0, 15)));
        write_register(CFG_REPORT_LIMIT, 8'($urandom_range(1, 63)));
      end
      send_random_request();
    end
    burst_mode = 0;
    rx_steady = 0;
  endtask

  task automatic test_backpressure();
    rx_hold_req = 400;
    burst_mode = 1;
    for (int k = 0; k < 30; k++) send_random_request();
    burst_mode = 0;
  endtask

  task automatic test_drain_pause();
    stop_sending();
    wait_drained();
    for (int k = 0; k < 20; k++) send_random_request();
  endtask

  initial begin
    for (int k = 0; k < 1024; k++) window_map[k] = 0;
    delivered_upto = '1;
    newest_seq = '1;
    local_channel = '0;
    word_limit = LIMIT_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config();
    test_backpressure();
    test_drain_pause();
    test_random(420);
    write_register(CFG_LOCAL_CHANNEL, 8'd0);
    write_register(CFG_REPORT_LIMIT, 8'd63);
    send_request(MODE_REPORT, 10'd0, 4'd0);
    stop_sending();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** receive_window_nack_tracker_top: PASSED **");
    end else begin
      $display("** receive_window_nack_tracker_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
